### sv/cpu8_pkg.sv
package cpu8_pkg;

  // Architectural state, flags packed as {S, Z, AC, P, CY}
  typedef struct packed {
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [7:0]  a;
    logic [4:0]  flags;
    logic [15:0] sp;
    logic [15:0] pc;
  } cpu_state_t;

  typedef enum logic [1:0] {
    STAT_EXEC  = 2'd0,
    STAT_HALT  = 2'd1,
    STAT_UNSUP = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [15:0] hl_pair;
    logic [1:0]  write_count;
    logic [15:0] write_addr;
    logic [7:0]  write_first;
    logic [7:0]  write_second;
    logic [7:0]  accumulator;
    logic [4:0]  flag_bits;
    status_e     status;
  } result_t;

  // Flag bit positions
  localparam int unsigned FlagS  = 4;
  localparam int unsigned FlagZ  = 3;
  localparam int unsigned FlagAc = 2;
  localparam int unsigned FlagP  = 1;
  localparam int unsigned FlagCy = 0;

  // Register codes in opcode fields
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegM = 3'd6;
  localparam logic [2:0] RegA = 3'd7;

  // Register pair codes
  localparam logic [1:0] PairBc = 2'd0;
  localparam logic [1:0] PairDe = 2'd1;
  localparam logic [1:0] PairHl = 2'd2;
  localparam logic [1:0] PairSp = 2'd3;

  // ALU operation codes (opcode bits 5:3 of the 0x80 group)
  localparam logic [2:0] AluAdd = 3'd0;
  localparam logic [2:0] AluAdc = 3'd1;
  localparam logic [2:0] AluSub = 3'd2;
  localparam logic [2:0] AluSbb = 3'd3;
  localparam logic [2:0] AluAna = 3'd4;
  localparam logic [2:0] AluXra = 3'd5;
  localparam logic [2:0] AluOra = 3'd6;
  localparam logic [2:0] AluCmp = 3'd7;

  localparam logic [7:0] OpHlt = 8'h76;
  localparam logic [7:0] OpRlc = 8'h07;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 88;

  // S, Z and P for an 8-bit result; AC and CY left clear
  function automatic logic [4:0] szp(input logic [7:0] v);
    logic [4:0] f;
    f         = 5'd0;
    f[FlagS]  = v[7];
    f[FlagZ]  = (v == 8'd0);
    f[FlagP]  = ~^v;
    return f;
  endfunction

endpackage

### sv/cpu8_alu.sv
module cpu8_alu (
  input  logic [2:0] sel_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic       cin_i,
  output logic [7:0] res_o,
  output logic [4:0] flags_o
);

  logic [7:0] nb;
  logic       c_add;
  logic       c_sub;
  logic [8:0] sum_add;
  logic [8:0] sum_sub;
  logic [4:0] nib_add;
  logic [4:0] nib_sub;
  logic       cy;
  logic       ac;

  assign nb    = ~b_i;
  assign c_add = (sel_i == cpu8_pkg::AluAdc) & cin_i;
  // borrow-in inverted: carry of A + ~B + (1 - borrow)
  assign c_sub = ~((sel_i == cpu8_pkg::AluSbb) & cin_i);

  assign sum_add = {1'b0, a_i} + {1'b0, b_i} + {8'd0, c_add};
  assign sum_sub = {1'b0, a_i} + {1'b0, nb} + {8'd0, c_sub};
  assign nib_add = {1'b0, a_i[3:0]} + {1'b0, b_i[3:0]} + {4'd0, c_add};
  assign nib_sub = {1'b0, a_i[3:0]} + {1'b0, nb[3:0]} + {4'd0, c_sub};

  always_comb begin
    res_o = 8'd0;
    cy    = 1'b0;
    ac    = 1'b0;
    unique case (sel_i)
      cpu8_pkg::AluAdd, cpu8_pkg::AluAdc: begin
        res_o = sum_add[7:0];
        cy    = sum_add[8];
        ac    = nib_add[4];
      end
      cpu8_pkg::AluSub, cpu8_pkg::AluSbb: begin
        res_o = sum_sub[7:0];
        cy    = ~sum_sub[8];
        ac    = nib_sub[4];
      end
      cpu8_pkg::AluAna: begin
        res_o = a_i & b_i;
        ac    = a_i[3] | b_i[3];
      end
      cpu8_pkg::AluXra: begin
        res_o = a_i ^ b_i;
      end
      cpu8_pkg::AluOra, cpu8_pkg::AluCmp: begin
        res_o = a_i | b_i;
      end
      default: begin
        res_o = 8'd0;
      end
    endcase
    flags_o                  = cpu8_pkg::szp(res_o);
    flags_o[cpu8_pkg::FlagAc] = ac;
    flags_o[cpu8_pkg::FlagCy] = cy;
  end

endmodule

### sv/cpu8_exec.sv
module cpu8_exec (
  input  cpu8_pkg::cpu_state_t st_i,
  input  logic [7:0]           opcode_i,
  input  logic [7:0]           byte_two_i,
  input  logic [7:0]           byte_three_i,
  input  logic [7:0]           mem_operand_i,
  output cpu8_pkg::cpu_state_t st_o,
  output cpu8_pkg::result_t    res_o
);

  function automatic logic [7:0] reg_rd(input cpu8_pkg::cpu_state_t s,
                                        input logic [2:0] code);
    logic [7:0] v;
    unique case (code)
      cpu8_pkg::RegB: v = s.b;
      cpu8_pkg::RegC: v = s.c;
      cpu8_pkg::RegD: v = s.d;
      cpu8_pkg::RegE: v = s.e;
      cpu8_pkg::RegH: v = s.h;
      cpu8_pkg::RegL: v = s.l;
      cpu8_pkg::RegA: v = s.a;
      default:        v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic cpu8_pkg::cpu_state_t reg_wr(input cpu8_pkg::cpu_state_t s,
                                                  input logic [2:0] code,
                                                  input logic [7:0] v);
    cpu8_pkg::cpu_state_t r;
    r = s;
    unique case (code)
      cpu8_pkg::RegB: r.b = v;
      cpu8_pkg::RegC: r.c = v;
      cpu8_pkg::RegD: r.d = v;
      cpu8_pkg::RegE: r.e = v;
      cpu8_pkg::RegH: r.h = v;
      cpu8_pkg::RegL: r.l = v;
      cpu8_pkg::RegA: r.a = v;
      default:        r = s;
    endcase
    return r;
  endfunction

  // rp 3 reads SP here
  function automatic logic [15:0] pair_rd(input cpu8_pkg::cpu_state_t s,
                                          input logic [1:0] rp);
    logic [15:0] v;
    unique case (rp)
      cpu8_pkg::PairBc: v = {s.b, s.c};
      cpu8_pkg::PairDe: v = {s.d, s.e};
      cpu8_pkg::PairHl: v = {s.h, s.l};
      default:          v = s.sp;
    endcase
    return v;
  endfunction

  function automatic cpu8_pkg::cpu_state_t pair_wr(input cpu8_pkg::cpu_state_t s,
                                                   input logic [1:0] rp,
                                                   input logic [15:0] v);
    cpu8_pkg::cpu_state_t r;
    r = s;
    unique case (rp)
      cpu8_pkg::PairBc: {r.b, r.c} = v;
      cpu8_pkg::PairDe: {r.d, r.e} = v;
      cpu8_pkg::PairHl: {r.h, r.l} = v;
      default:          r.sp = v;
    endcase
    return r;
  endfunction

  logic [3:0]  lo;
  logic [1:0]  rp;
  logic [2:0]  dst;
  logic [2:0]  src;
  logic [15:0] hl;
  logic [15:0] imm;
  logic [7:0]  src_val;
  logic [7:0]  dst_val;
  logic [7:0]  alu_res;
  logic [4:0]  alu_flags;
  logic [16:0] dad_sum;
  logic [1:0]  len;
  cpu8_pkg::status_e    status;
  cpu8_pkg::cpu_state_t st_n;
  logic [1:0]  wcount;
  logic [15:0] waddr;
  logic [7:0]  wfirst;
  logic [7:0]  wsecond;

  assign lo      = opcode_i[3:0];
  assign rp      = opcode_i[5:4];
  assign dst     = opcode_i[5:3];
  assign src     = opcode_i[2:0];
  assign hl      = {st_i.h, st_i.l};
  assign imm     = {byte_three_i, byte_two_i};
  assign src_val = (src == cpu8_pkg::RegM) ? mem_operand_i : reg_rd(st_i, src);
  assign dst_val = reg_rd(st_i, dst);
  assign dad_sum = {1'b0, hl} + {1'b0, pair_rd(st_i, rp)};

  cpu8_alu u_alu (
    .sel_i   (dst),
    .a_i     (st_i.a),
    .b_i     (src_val),
    .cin_i   (st_i.flags[cpu8_pkg::FlagCy]),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  always_comb begin
    st_n    = st_i;
    status  = cpu8_pkg::STAT_EXEC;
    len     = 2'd1;
    wcount  = 2'd0;
    waddr   = 16'd0;
    wfirst  = 8'd0;
    wsecond = 8'd0;
    unique case (opcode_i[7:6])
      2'b00: begin
        unique case (lo)
          4'h0, 4'h8: begin
          end
          4'h1: begin // LXI
            st_n = pair_wr(st_i, rp, imm);
            len  = 2'd3;
          end
          4'h2: begin // STAX, SHLD, STA
            wcount = 2'd1;
            wfirst = st_i.a;
            unique case (rp)
              cpu8_pkg::PairBc, cpu8_pkg::PairDe: waddr = pair_rd(st_i, rp);
              cpu8_pkg::PairHl: begin
                waddr   = imm;
                wfirst  = st_i.l;
                wsecond = st_i.h;
                wcount  = 2'd2;
                len     = 2'd3;
              end
              default: begin
                waddr = imm;
                len   = 2'd3;
              end
            endcase
          end
          4'h3: begin // INX
            st_n = pair_wr(st_i, rp, pair_rd(st_i, rp) + 16'd1);
          end
          4'h4, 4'hC, 4'h5, 4'hD: begin // INR / DCR
            if (dst == cpu8_pkg::RegM) begin
              status = cpu8_pkg::STAT_UNSUP;
            end else if (!lo[0]) begin
              st_n = reg_wr(st_i, dst, dst_val + 8'd1);
              st_n.flags = cpu8_pkg::szp(dst_val + 8'd1);
              st_n.flags[cpu8_pkg::FlagAc] = (dst_val[3:0] == 4'hF);
              st_n.flags[cpu8_pkg::FlagCy] = st_i.flags[cpu8_pkg::FlagCy];
            end else begin
              st_n = reg_wr(st_i, dst, dst_val - 8'd1);
              st_n.flags = cpu8_pkg::szp(dst_val - 8'd1);
              st_n.flags[cpu8_pkg::FlagAc] = (dst_val[3:0] != 4'h0);
              st_n.flags[cpu8_pkg::FlagCy] = st_i.flags[cpu8_pkg::FlagCy];
            end
          end
          4'h6, 4'hE: begin // MVI
            len = 2'd2;
            if (dst == cpu8_pkg::RegM) begin
              wcount = 2'd1;
              waddr  = hl;
              wfirst = byte_two_i;
            end else begin
              st_n = reg_wr(st_i, dst, byte_two_i);
            end
          end
          4'h7: begin
            if (opcode_i == cpu8_pkg::OpRlc) begin
              st_n.a = {st_i.a[6:0], st_i.a[7]};
              st_n.flags[cpu8_pkg::FlagCy] = st_i.a[7];
            end else begin
              status = cpu8_pkg::STAT_UNSUP;
            end
          end
          4'h9: begin // DAD
            if (rp == cpu8_pkg::PairSp) begin
              status = cpu8_pkg::STAT_UNSUP;
            end else begin
              st_n.h = dad_sum[15:8];
              st_n.l = dad_sum[7:0];
              st_n.flags[cpu8_pkg::FlagCy] = dad_sum[16];
            end
          end
          default: begin
            status = cpu8_pkg::STAT_UNSUP;
          end
        endcase
      end
      2'b01: begin
        if (opcode_i == cpu8_pkg::OpHlt) begin
          status = cpu8_pkg::STAT_HALT;
        end else if (dst == cpu8_pkg::RegM) begin
          wcount = 2'd1;
          waddr  = hl;
          wfirst = src_val;
        end else begin
          st_n = reg_wr(st_i, dst, src_val);
        end
      end
      2'b10: begin
        if (dst == cpu8_pkg::AluCmp) begin
          status = cpu8_pkg::STAT_UNSUP;
        end else begin
          st_n.a     = alu_res;
          st_n.flags = alu_flags;
        end
      end
      default: begin
        status = cpu8_pkg::STAT_UNSUP;
      end
    endcase

    if (status != cpu8_pkg::STAT_EXEC) begin
      st_n    = st_i;
      wcount  = 2'd0;
      waddr   = 16'd0;
      wfirst  = 8'd0;
      wsecond = 8'd0;
    end else begin
      st_n.pc = st_i.pc + {14'd0, len};
    end
  end

  assign st_o = st_n;

  assign res_o.next_pc      = st_n.pc;
  assign res_o.hl_pair      = {st_n.h, st_n.l};
  assign res_o.write_count  = wcount;
  assign res_o.write_addr   = waddr;
  assign res_o.write_first  = wfirst;
  assign res_o.write_second = wsecond;
  assign res_o.accumulator  = st_n.a;
  assign res_o.flag_bits    = st_n.flags;
  assign res_o.status       = status;

endmodule

### sv/eight_bit_cpu_execute_subset_top.sv
// Executes one instruction of an 8080 subset per input item and returns one result item.
// Each item brings the opcode, the two bytes after it and the memory byte at HL; the block
// keeps B, C, D, E, H, L, A, the five flags, SP and PC, all cleared by reset. The input
// register takes the item at its accepting edge, and the item is executed into the result
// register once that slot is free or being taken. One item is taken every cycle while the
// output is drained: the architectural state is written at the same edge as the result, so
// the next item already sees it. HLT and unsupported opcodes leave all state alone and report
// status 1 or 2 with no memory write. Memory writes are not performed here; they are reported
// for the caller to do.
module eight_bit_cpu_execute_subset_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // opcode[7:0], byte_two[15:8], byte_three[23:16], mem_operand[31:24]
  input  logic [cpu8_pkg::InWidth-1:0]       s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // next_pc[15:0], hl_pair[31:16], write_count[33:32], write_addr[49:34],
  // write_first[57:50], write_second[65:58], accumulator[73:66],
  // flag_bits[78:74], status[80:79], zero[87:81]
  output logic [cpu8_pkg::OutWidth-1:0]      m_axis_tdata_o
);

  // input register
  logic                            in_vld_q, in_vld_d;
  logic [cpu8_pkg::InWidth-1:0]    in_data_q;
  // result register
  logic                            out_vld_q, out_vld_d;
  cpu8_pkg::result_t               res_q;
  // architectural state
  cpu8_pkg::cpu_state_t            st_q, st_d;

  cpu8_pkg::cpu_state_t            exec_st;
  cpu8_pkg::result_t               exec_res;
  logic                            advance;
  logic                            fire;

  // result slot free or being taken this cycle
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign fire            = advance && in_vld_q;
  assign s_axis_tready_o = !in_vld_q || advance;

  cpu8_exec u_exec (
    .st_i          (st_q),
    .opcode_i      (in_data_q[7:0]),
    .byte_two_i    (in_data_q[15:8]),
    .byte_three_i  (in_data_q[23:16]),
    .mem_operand_i (in_data_q[31:24]),
    .st_o          (exec_st),
    .res_o         (exec_res)
  );

  always_comb begin
    in_vld_d  = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;
    out_vld_d = advance ? in_vld_q : out_vld_q;
    st_d      = fire ? exec_st : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (fire) begin
      res_q <= exec_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0,
                            res_q.status,
                            res_q.flag_bits,
                            res_q.accumulator,
                            res_q.write_second,
                            res_q.write_first,
                            res_q.write_addr,
                            res_q.write_count,
                            res_q.hl_pair,
                            res_q.next_pc};

endmodule

### sv/cpu8_checker.sv
module cpu8_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cpu8_pkg::OutWidth-1:0] m_axis_tdata_o
);

  logic [1:0] st_code;
  logic [1:0] wcnt;

  assign st_code = m_axis_tdata_o[80:79];
  assign wcnt    = m_axis_tdata_o[33:32];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // an empty result slot never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with no result waiting");

  // status and write count stay within their codes; padding is zero
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> st_code != 2'd3 && wcnt != 2'd3 && m_axis_tdata_o[87:81] == 7'd0)
    else $error("illegal status or write count");

  // halt and unsupported report no memory write
  a_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st_code != cpu8_pkg::STAT_EXEC |->
      wcnt == 2'd0 && m_axis_tdata_o[65:34] == 32'd0)
    else $error("write reported on non-executed item");

  // a two-byte write is SHLD: it stores L then H of the unchanged HL
  a_shld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && wcnt == 2'd2 |->
      m_axis_tdata_o[57:50] == m_axis_tdata_o[23:16] &&
      m_axis_tdata_o[65:58] == m_axis_tdata_o[31:24])
    else $error("SHLD data does not match HL");

endmodule

bind eight_bit_cpu_execute_subset_top cpu8_checker u_cpu8_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
